/* hw/rtl/qmbe_pkg.sv */
// Shared types, constants and arithmetic helpers of the monomial basis evaluator.
package qmbe_pkg;

    localparam int MAX_DEGREE_DEF = 7;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int MID_DEPTH      = 2;
    localparam int OUT_DEPTH      = 8;
    localparam int IDX_W          = 6;
    localparam int DEG_W          = 3;
    localparam int MODE_W         = 2;
    localparam int CFG_DATA_W     = 3;

    typedef enum logic [0:0] {
        REG_DEGREE = 1'b0,
        REG_MODE   = 1'b1
    } cfg_reg_t;

    localparam logic [MODE_W-1:0] MODE_VALUE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DX    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DY    = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] basis_index;
        logic             last_in_run;
        logic             batch_end;
    } tag_t;

    typedef struct packed {
        logic signed [31:0] value;
        tag_t               tag;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round to nearest with ties up, drop fb fraction bits, saturate
    function automatic logic signed [31:0] fx_round(input logic signed [63:0] t,
                                                    input int unsigned fb);
        logic signed [63:0] s;
        s = t + (64'sd1 <<< (fb - 1));
        s = s >>> fb;
        return sat32(s);
    endfunction

endpackage

/* hw/rtl/quad_monomial_basis_eval_core.sv */
// Top level of the tensor-product monomial basis evaluator.
// For each point (x,y) the core emits (d+1)^2 words, d being the degree register
// clamped to MAX_DEGREE, in shell order 1, x, y, xy, then x^k*y^j and x^(k-j)*y^k
// for each shell k; basis_mode picks values, d/dx or d/dy. Each point's words leave
// the result port one word per cycle, so a run of points sustains one result word
// per clock whenever pop is held high. The front end expands the power tables of
// a point and overlaps that work with the previous run.
module quad_monomial_basis_eval_core
    import qmbe_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic signed [15:0]    x,
    input  logic signed [15:0]    y,
    input  logic                  last_point,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [31:0]    value,
    output logic [IDX_W-1:0]      basis_index,
    output logic                  last_in_run,
    output logic                  batch_end
);

    localparam int EW = $clog2(MAX_DEGREE + 1);
    localparam int QW = 2 * (MAX_DEGREE + 1) * 32 + 1;
    localparam int RW = $bits(res_t);

    logic [DEG_W-1:0]  degree_reg;
    logic [MODE_W-1:0] basis_mode_reg;
    logic [EW-1:0]     deg;

    logic              mid_push, mid_full, mid_pop, mid_empty;
    logic [QW-1:0]     mid_din, mid_dout;
    logic              res_valid, out_full, credit;
    res_t              res, out_word;
    logic [RW-1:0]     out_dout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg     <= DEG_W'(1);
            basis_mode_reg <= MODE_VALUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEGREE: degree_reg     <= cfg_data[DEG_W-1:0];
                REG_MODE:   basis_mode_reg <= cfg_data[MODE_W-1:0];
            endcase
        end
    end

    assign deg = (32'(degree_reg) > MAX_DEGREE) ? EW'(MAX_DEGREE) : EW'(degree_reg);

    qmbe_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW),
        .QW         (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .deg        (deg),
        .push       (push),
        .full       (full),
        .x          (x),
        .y          (y),
        .last_point (last_point),
        .q_push     (mid_push),
        .q_word     (mid_din),
        .q_full     (mid_full)
    );

    qmbe_fifo #(
        .W     (QW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_din),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    qmbe_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW),
        .QW         (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .deg       (deg),
        .mode      (basis_mode_reg),
        .q_empty   (mid_empty),
        .q_word    (mid_dout),
        .q_pop     (mid_pop),
        .credit    (credit),
        .res_valid (res_valid),
        .res       (res)
    );

    assign credit = pop && !empty;

    qmbe_fifo #(
        .W     (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .din   (res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign out_word    = res_t'(out_dout);
    assign value       = out_word.value;
    assign basis_index = out_word.tag.basis_index;
    assign last_in_run = out_word.tag.last_in_run;
    assign batch_end   = out_word.tag.batch_end;

    no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("result word arrived at a full output queue");

    last_word_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_in_run && basis_index == '0) |-> (deg == '0))
        else $error("single-word run with nonzero degree");

    run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && $past(res_valid) && $past(res.tag.last_in_run))
            |-> (res.tag.basis_index == '0))
        else $error("run after a last word does not start at index zero");

endmodule

/* hw/rtl/qmbe_fifo.sv */
// Small first-in first-out queue of fixed-width words.
module qmbe_fifo
    import qmbe_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    ptr_match_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

    ptr_match_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while full");

endmodule

/* hw/rtl/qmbe_front.sv */
// Front end: accept points and expand the power tables of x and y.
module qmbe_front
    import qmbe_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int EW         = $clog2(MAX_DEGREE + 1),
    parameter int QW         = 2 * (MAX_DEGREE + 1) * 32 + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [EW-1:0]       deg,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  x,
    input  logic signed [15:0]  y,
    input  logic                last_point,
    output logic                q_push,
    output logic [QW-1:0]       q_word,
    input  logic                q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_HOLD = 3'b100
    } fstate_t;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    fstate_t                  state_reg, state_next;
    logic [EW-1:0]            n_reg, n_next;
    logic signed [15:0]       x_reg, y_reg;
    logic                     last_reg;
    logic signed [31:0]       cur_x_reg, cur_y_reg;
    logic [MAX_DEGREE:0][31:0] px_reg, py_reg;
    logic signed [47:0]       mx, my;
    logic signed [31:0]       nxt_x, nxt_y;
    logic                     accept;
    logic [EW:0]              n_inc;

    assign mx     = cur_x_reg * x_reg;
    assign my     = cur_y_reg * y_reg;
    assign nxt_x  = fx_round(64'(mx), FRAC_BITS);
    assign nxt_y  = fx_round(64'(my), FRAC_BITS);
    assign n_inc  = {1'b0, n_reg} + 1'b1;

    assign full   = !((state_reg == F_IDLE) || ((state_reg == F_HOLD) && !q_full));
    assign accept = push && !full;
    assign q_push = (state_reg == F_HOLD);
    assign q_word = {last_reg, py_reg, px_reg};

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (deg <= EW'(1)) ? F_HOLD : F_CALC;
                    n_next     = EW'(1);
                end
            end
            F_CALC:
            begin
                n_next = n_inc[EW-1:0];
                if (n_inc == {1'b0, deg})
                begin
                    state_next = F_HOLD;
                end
            end
            F_HOLD:
            begin
                if (accept)
                begin
                    state_next = (deg <= EW'(1)) ? F_HOLD : F_CALC;
                    n_next     = EW'(1);
                end
                else if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= x;
            y_reg     <= y;
            last_reg  <= last_point;
            cur_x_reg <= 32'(x);
            cur_y_reg <= 32'(y);
            px_reg[0] <= ONE;
            py_reg[0] <= ONE;
            px_reg[1] <= 32'(x);
            py_reg[1] <= 32'(y);
        end
        else if (state_reg == F_CALC)
        begin
            cur_x_reg <= nxt_x;
            cur_y_reg <= nxt_y;
            for (int i = 2; i <= MAX_DEGREE; i++)
            begin
                if (n_reg == EW'(i - 1))
                begin
                    px_reg[i] <= nxt_x;
                    py_reg[i] <= nxt_y;
                end
            end
        end
    end

    calc_below_degree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CALC) |-> (n_reg < deg))
        else $error("power step beyond degree");

    hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == F_HOLD) && q_full && !accept) |=> (state_reg == F_HOLD))
        else $error("power table dropped before queue took it");

    step_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == F_CALC) && !accept) |=> (n_reg == $past(n_reg) + 1'b1))
        else $error("power step counter did not advance");

endmodule

/* hw/rtl/qmbe_back.sv */
// Back end: walk the shell order and form each monomial or derivative.
module qmbe_back
    import qmbe_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int EW         = $clog2(MAX_DEGREE + 1),
    parameter int QW         = 2 * (MAX_DEGREE + 1) * 32 + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [EW-1:0]     deg,
    input  logic [MODE_W-1:0] mode,
    input  logic              q_empty,
    input  logic [QW-1:0]     q_word,
    output logic              q_pop,
    input  logic              credit,
    output logic              res_valid,
    output res_t              res
);

    localparam int OW = $clog2(OUT_DEPTH + 1);

    logic                      active_reg;
    logic [EW-1:0]             a_reg, b_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [OW-1:0]             occ_reg, occ_next;
    logic [MAX_DEGREE:0][31:0] px_reg, py_reg;
    logic                      last_reg;

    logic [MAX_DEGREE:0][31:0] ld_px, ld_py;
    logic                      ld_last;

    logic                      issue, shell_end, term_last;
    logic [EW-1:0]             k, na, nb;
    logic [EW-1:0]             ea, eb, coef;
    logic                      zero;

    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [31:0]        s1_pa_reg, s1_pb_reg;
    logic signed [63:0]        s2_prod_reg;
    logic signed [31:0]        s3_mono_reg;
    logic [EW-1:0]             s1_coef_reg, s2_coef_reg, s3_coef_reg;
    logic                      s1_zero_reg, s2_zero_reg, s3_zero_reg;
    tag_t                      s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic signed [EW+32:0]     cm;

    assign {ld_last, ld_py, ld_px} = q_word;

    assign issue = active_reg && (occ_reg < OW'(OUT_DEPTH));
    assign k     = (a_reg > b_reg) ? a_reg : b_reg;

    assign shell_end = (k == '0)
                    || ((a_reg == EW'(1)) && (b_reg == EW'(1)))
                    || ((k > EW'(1)) && (a_reg == '0) && (b_reg == k));
    assign term_last = shell_end && (k == deg);
    assign q_pop     = !q_empty && (!active_reg || (issue && term_last));

    always_comb
    begin
        na = a_reg;
        nb = b_reg;
        if (shell_end)
        begin
            na = k + 1'b1;
            nb = '0;
        end
        else if (k == EW'(1))
        begin
            if (b_reg == '0)
            begin
                na = '0;
                nb = EW'(1);
            end
            else
            begin
                na = EW'(1);
                nb = EW'(1);
            end
        end
        else if (b_reg < k)
        begin
            nb = b_reg + 1'b1;
        end
        else
        begin
            na = a_reg - 1'b1;
        end
    end

    always_comb
    begin
        ea   = a_reg;
        eb   = b_reg;
        coef = EW'(1);
        zero = 1'b0;
        unique case (mode)
            MODE_DX:
            begin
                zero = (a_reg == '0);
                ea   = zero ? '0 : a_reg - 1'b1;
                coef = a_reg;
            end
            MODE_DY:
            begin
                zero = (b_reg == '0);
                eb   = zero ? '0 : b_reg - 1'b1;
                coef = b_reg;
            end
            default:
            begin
                coef = EW'(1);
            end
        endcase
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (issue && !credit)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (credit && !issue)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            idx_reg      <= '0;
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (q_pop)
            begin
                active_reg <= 1'b1;
            end
            else if (issue && term_last)
            begin
                active_reg <= 1'b0;
            end
            if (issue)
            begin
                if (term_last)
                begin
                    a_reg   <= '0;
                    b_reg   <= '0;
                    idx_reg <= '0;
                end
                else
                begin
                    a_reg   <= na;
                    b_reg   <= nb;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            px_reg   <= ld_px;
            py_reg   <= ld_py;
            last_reg <= ld_last;
        end
        s1_pa_reg              <= px_reg[ea];
        s1_pb_reg              <= py_reg[eb];
        s1_coef_reg            <= coef;
        s1_zero_reg            <= zero;
        s1_tag_reg.basis_index <= idx_reg;
        s1_tag_reg.last_in_run <= term_last;
        s1_tag_reg.batch_end   <= last_reg;

        s2_prod_reg <= s1_pa_reg * s1_pb_reg;
        s2_coef_reg <= s1_coef_reg;
        s2_zero_reg <= s1_zero_reg;
        s2_tag_reg  <= s1_tag_reg;

        s3_mono_reg <= fx_round(s2_prod_reg, FRAC_BITS);
        s3_coef_reg <= s2_coef_reg;
        s3_zero_reg <= s2_zero_reg;
        s3_tag_reg  <= s2_tag_reg;
    end

    assign cm        = $signed({1'b0, s3_coef_reg}) * s3_mono_reg;
    assign res_valid = s3_valid_reg;
    assign res.value = s3_zero_reg ? 32'sd0 : sat32(64'(cm));
    assign res.tag   = s3_tag_reg;

    occ_within_depth: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(OUT_DEPTH))
        else $error("result credits exceed queue depth");

    index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !term_last) |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("basis index did not advance");

    index_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && term_last) |=> (idx_reg == '0) && (a_reg == '0) && (b_reg == '0))
        else $error("run did not restart at the first monomial");

    result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (occ_reg != '0))
        else $error("result word without reserved queue slot");

endmodule

/* verif/tb_quad_monomial_basis_eval_core.sv */
// Self-checking testbench of the monomial basis evaluator against an in-bench predictor.
`timescale 1ns / 100ps
module tb_quad_monomial_basis_eval_core;
    import qmbe_pkg::*;

    localparam int     FRAC          = FRAC_BITS_DEF;
    localparam int     TOP_DEGREE    = MAX_DEGREE_DEF;
    localparam longint SAT_HI        = 64'sd2147483647;
    localparam longint SAT_LO        = -64'sd2147483648;
    localparam int     LONG_HOLD     = 300;
    localparam int     DRAIN_CYCLES  = 80;
    localparam int     LIMIT_CYCLES  = 1000000;
    localparam int     RANDOM_POINTS = 280;
    localparam int     QUIET_POINTS  = 20;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     FILL_BURST    = 24;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               lp;
    } point_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [0:0]            cfg_index  = REG_DEGREE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  push       = 1'b0;
    logic signed [15:0]    x          = '0;
    logic signed [15:0]    y          = '0;
    logic                  last_point = 1'b0;
    logic                  pop        = 1'b0;
    wire                   full;
    wire                   empty;
    wire signed [31:0]     value;
    wire [IDX_W-1:0]       basis_index;
    wire                   last_in_run;
    wire                   batch_end;

    logic [DEG_W-1:0]  degree_reg = 3'd1;
    logic [MODE_W-1:0] mode_reg   = MODE_VALUE;

    point_t pending_points[$];
    res_t   expected_words[$];

    int          error_count     = 0;
    int          points_accepted = 0;
    int          words_checked   = 0;
    int          config_count    = 0;
    int unsigned cycle_count     = 0;
    logic        quiet           = 1'b0;
    int          rx_hold_id      = 0;
    int          rx_hold_seen    = 0;
    int          rx_hold_left    = 0;
    int          rx_stall        = 0;
    int          tx_gap          = 0;

    quad_monomial_basis_eval_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .x           (x),
        .y           (y),
        .last_point  (last_point),
        .empty       (empty),
        .pop         (pop),
        .value       (value),
        .basis_index (basis_index),
        .last_in_run (last_in_run),
        .batch_end   (batch_end)
    );

    always #1 clk = ~clk;

    function automatic longint clip32(input longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    function automatic longint requantize(input longint t);
        return clip32((t + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic longint fixed_power(input longint v, input int n);
        longint p;
        if (n == 0)
            return 64'sd1 <<< FRAC;
        p = v;
        for (int i = 1; i < n; i++)
            p = requantize(p * v);
        return p;
    endfunction

    function automatic longint monomial(input longint px, input longint py,
                                        input int a, input int b);
        return requantize(fixed_power(px, a) * fixed_power(py, b));
    endfunction

    function automatic longint basis_term(input longint px, input longint py,
                                          input int a, input int b,
                                          input logic [MODE_W-1:0] mode);
        if (mode == MODE_DX)
            return (a == 0) ? 64'sd0 : clip32(a * monomial(px, py, a - 1, b));
        if (mode == MODE_DY)
            return (b == 0) ? 64'sd0 : clip32(b * monomial(px, py, a, b - 1));
        return monomial(px, py, a, b);
    endfunction

    task automatic predict_point(input logic signed [15:0] px, input logic signed [15:0] py,
                                 input logic lp);
        int     ea[64];
        int     eb[64];
        int     d;
        int     n;
        longint v;
        res_t   w;
        d = int'(degree_reg);
        if (d > TOP_DEGREE)
            d = TOP_DEGREE;
        ea[0] = 0;
        eb[0] = 0;
        n = 1;
        if (d > 0)
        begin
            ea[1] = 1; eb[1] = 0;
            ea[2] = 0; eb[2] = 1;
            ea[3] = 1; eb[3] = 1;
            n = 4;
            for (int k = 2; k <= d; k++)
            begin
                for (int j = 0; j <= k; j++)
                begin
                    ea[n] = k;
                    eb[n] = j;
                    n++;
                end
                for (int j = 1; j <= k; j++)
                begin
                    ea[n] = k - j;
                    eb[n] = k;
                    n++;
                end
            end
        end
        for (int s = 0; s < n; s++)
        begin
            v = basis_term(px, py, ea[s], eb[s], mode_reg);
            w.value           = v[31:0];
            w.tag.basis_index = IDX_W'(s);
            w.tag.last_in_run = (s == n - 1);
            w.tag.batch_end   = lp;
            expected_words.push_back(w);
        end
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    // sample handshakes: predict on accepted points, check popped words
    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t got;
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_point(x, y, last_point);
                points_accepted++;
            end
            if (pop && !empty)
            begin
                words_checked++;
                got = {value, basis_index, last_in_run, batch_end};
                if (expected_words.size() == 0)
                    note_error($sformatf("word with no pending expectation: value %0d index %0d",
                                         got.value, got.tag.basis_index));
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                        note_error($sformatf({"expected value %0d idx %0d last %0b end %0b, ",
                                              "got value %0d idx %0d last %0b end %0b"},
                                             want.value, want.tag.basis_index,
                                             want.tag.last_in_run, want.tag.batch_end,
                                             got.value, got.tag.basis_index,
                                             got.tag.last_in_run, got.tag.batch_end));
                end
            end
        end
    end

    // point driver: hold a word while full, insert random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                void'(pending_points.pop_front());
            if (!(push && full))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    push <= 1'b0;
                end
                else if (pending_points.size() == 0)
                    push <= 1'b0;
                else if (!quiet && $urandom_range(0, 15) == 0)
                begin
                    tx_gap = $urandom_range(0, 10);
                    push <= 1'b0;
                end
                else
                begin
                    push       <= 1'b1;
                    x          <= pending_points[0].px;
                    y          <= pending_points[0].py;
                    last_point <= pending_points[0].lp;
                end
            end
        end
    end

    // result receiver: random stall bursts and one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_hold_seen != rx_hold_id)
        begin
            rx_hold_seen = rx_hold_id;
            rx_hold_left = LONG_HOLD;
            pop <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            rx_stall = $urandom_range(0, 10);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_config(input logic [CFG_DATA_W-1:0] deg_data,
                              input logic [CFG_DATA_W-1:0] mode_data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEGREE;
        cfg_data  <= deg_data;
        @(posedge clk);
        cfg_index <= REG_MODE;
        cfg_data  <= mode_data;
        @(posedge clk);
        cfg_we <= 1'b0;
        degree_reg = deg_data[DEG_W-1:0];
        mode_reg   = mode_data[MODE_W-1:0];
        config_count++;
    endtask

    task automatic add_point(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic lp);
        point_t p;
        p.px = px;
        p.py = py;
        p.lp = lp;
        pending_points.push_back(p);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || push || expected_words.size() != 0);
    endtask

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 4096) - 2048);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic random_phase(input int count);
        set_config(3'($urandom_range(0, 3) == 0 ? $urandom_range(4, 7) : $urandom_range(0, 3)),
                   3'($urandom_range(0, 7)));
        for (int i = 0; i < count; i++)
            add_point(random_coord(), random_coord(), $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        int random_sent;
        int phase;
        int burst;
        random_sent = 0;
        phase = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: degree one, values
        add_point(16'sd0, 16'sd0, 1'b0);
        add_point(16'sd16384, -16'sd16384, 1'b0);
        add_point(16'sd32767, -16'sd32768, 1'b1);
        add_point(-16'sd1, 16'sd1, 1'b0);
        wait_drained();

        set_config(3'd7, MODE_VALUE);
        add_point(16'sd16384, 16'sd16384, 1'b0);
        add_point(-16'sd32768, 16'sd32767, 1'b1);
        add_point(16'sd8192, -16'sd24576, 1'b0);
        wait_drained();

        set_config(3'd7, MODE_DX);
        add_point(16'sd16384, -16'sd16384, 1'b1);
        add_point(-16'sd32768, -16'sd32768, 1'b0);
        add_point(16'sd0, 16'sd1, 1'b0);
        wait_drained();

        set_config(3'd7, {1'b1, MODE_DY});
        add_point(16'sd16384, -16'sd16384, 1'b0);
        add_point(-16'sd32768, -16'sd32768, 1'b1);
        add_point(16'sd1, 16'sd0, 1'b0);
        wait_drained();

        set_config(3'd0, MODE_VALUE);
        add_point(16'sd5, 16'sd7, 1'b1);
        wait_drained();
        set_config(3'd0, MODE_DX);
        add_point(-16'sd5, 16'sd7, 1'b0);
        wait_drained();
        set_config(3'd0, MODE_DY);
        add_point(16'sd5, -16'sd7, 1'b1);
        wait_drained();

        set_config(3'd3, MODE_SPARE);
        add_point(16'sd12000, -16'sd9000, 1'b0);
        add_point(-16'sd16384, 16'sd32767, 1'b1);
        wait_drained();

        while (random_sent < RANDOM_POINTS)
        begin
            burst = (phase == 1) ? FILL_BURST : $urandom_range(8, 24);
            if (phase == 1)
                rx_hold_id <= rx_hold_id + 1;
            random_phase(burst);
            random_sent += burst;
            wait_drained();
            phase++;
        end

        quiet <= 1'b1;
        random_phase(QUIET_POINTS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        error_count += expected_words.size();
        $display("Checked %0d result words from %0d points over %0d register settings,",
                 words_checked, points_accepted, config_count);
        $display("degrees 0 to 7, all mode codes, saturating inputs, stalls and a long hold-off.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
